// File: sv/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Types, constants and parse helpers shared by the sexagesimal text parser.
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam int MAX_STRING_DEF = 512;

    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int VALUE_W    = 18;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_OFFSET = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_LENGTH = 1'd1;

    // field saturation limits
    localparam logic [19:0] DEG_MAX = 20'd999;
    localparam logic [19:0] MIN_MAX = 20'd9999;
    localparam logic [19:0] SEC_MAX = 20'd99999;

    // floor(x / 225) = (x * RECIP) >> RECIP_SHIFT for every 25-bit x
    localparam int          RECIP_SHIFT = 33;
    localparam logic [25:0] RECIP       = 26'd38177488;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_DEG,
        PH_MIN,
        PH_SEC,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  deg;
        logic [13:0] min;
        logic [16:0] sec;
        logic [6:0]  frac;
        logic [1:0]  fdig;
        logic        stopped;
        logic        point;
        logic        neg;
        logic        begun;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        phase:   PH_DEG,
        deg:     10'd0,
        min:     14'd0,
        sec:     17'd0,
        frac:    7'd0,
        fdig:    2'd0,
        stopped: 1'b0,
        point:   1'b0,
        neg:     1'b0,
        begun:   1'b0
    };

    function automatic logic [19:0] f_push(logic [19:0] acc, logic [3:0] d,
                                           logic [19:0] limit);
        logic [19:0] v;
        v = acc * 20'd10 + 20'(d);
        return (v > limit) ? limit : v;
    endfunction

    function automatic t_parse f_next_phase(t_parse s, t_phase ph);
        t_parse r;
        r         = s;
        r.phase   = ph;
        r.stopped = 1'b0;
        r.point   = 1'b0;
        r.begun   = 1'b0;
        return r;
    endfunction

    function automatic t_parse f_field_char(t_parse s, logic [7:0] c);
        t_parse      r;
        logic [3:0]  d;
        logic [19:0] v;
        r = s;
        d = c[3:0];
        v = '0;
        if (!s.stopped) begin
            if (c inside {[CH_ZERO:CH_NINE]}) begin
                r.begun = 1'b1;
                if (s.point) begin
                    if (s.fdig < 2'd2) begin
                        r.frac = 7'(s.frac * 7'd10 + 7'(d));
                        r.fdig = s.fdig + 2'd1;
                    end
                end else begin
                    case (s.phase)
                        PH_DEG: begin
                            v     = f_push(20'(s.deg), d, DEG_MAX);
                            r.deg = v[9:0];
                        end
                        PH_MIN: begin
                            v     = f_push(20'(s.min), d, MIN_MAX);
                            r.min = v[13:0];
                        end
                        default: begin
                            v     = f_push(20'(s.sec), d, SEC_MAX);
                            r.sec = v[16:0];
                        end
                    endcase
                end
            end else if (c == CH_POINT && s.phase == PH_SEC && !s.point) begin
                r.point = 1'b1;
                r.begun = 1'b1;
            end else if (!s.begun && c inside {[CH_TAB:CH_CR]}) begin
                r = s;
            end else if (!s.begun && c == CH_PLUS) begin
                r.begun = 1'b1;
            end else begin
                r.stopped = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_parse f_parse_char(t_parse s, logic [7:0] c);
        t_parse r;
        logic   sep;
        logic   pos;
        logic   neg;
        r   = s;
        sep = c inside {CH_DASH, CH_COLON, CH_SPACE};
        pos = c inside {CH_N, CH_E};
        neg = c inside {CH_S, CH_W};
        case (s.phase)
            PH_DEG: begin
                r = sep ? f_next_phase(s, PH_MIN) : f_field_char(s, c);
            end
            PH_MIN, PH_SEC: begin
                if (sep || pos || neg) begin
                    if (pos) r.neg = 1'b0;
                    if (neg) r.neg = 1'b1;
                    r = f_next_phase(r, (s.phase == PH_MIN) ? PH_SEC : PH_DONE);
                end else begin
                    r = f_field_char(s, c);
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic t_parse f_end_string(t_parse s);
        t_parse r;
        r = s;
        case (s.phase)
            PH_DEG: r.phase = PH_FAIL;
            PH_MIN: begin
                r.min   = '0;
                r.phase = PH_DONE;
            end
            PH_SEC: begin
                r.sec   = '0;
                r.frac  = '0;
                r.fdig  = '0;
                r.phase = PH_DONE;
            end
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

// File: sv/sexagesimal_text_to_decimal_top.sv
// ----------------------------------------------------------------------------
// sexagesimal_text_to_decimal_top
// Degrees-minutes-seconds text stream to signed hundredths of a degree.
// ----------------------------------------------------------------------------
// Throughput: one character beat per cycle while the result side keeps up.
// Pipeline: the fields closed out by the beat carrying tlast pass through
//   the conversion pipeline, five registers deep, into the output register;
//   the pipeline holds up to five results when the result side stalls.
// Reset: synchronous, active low; clears parse state, pipeline valids and
//   both configuration registers.
// ----------------------------------------------------------------------------
module sexagesimal_text_to_decimal_top #(
    parameter int MAX_STRING = sdt_pkg::MAX_STRING_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // character stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
    input  logic                          s_axis_tlast,   // is_last
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // [17:0] value_hundredths
    output logic                          m_axis_tuser,   // [0] status
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [sdt_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sdt_pkg::CFG_W-1:0]     i_cfg_data
);
    logic [sdt_pkg::CFG_W-1:0]   r_start_offset;
    logic [sdt_pkg::CFG_W-1:0]   r_field_length;
    logic                        accept;
    logic                        fin_valid;
    sdt_pkg::t_parse             fin;
    logic [sdt_pkg::VALUE_W-1:0] value;

    // configuration registers: the user must write them only while the block is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
            r_field_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sdt_pkg::CFG_START_OFFSET: r_start_offset <= i_cfg_data;
                sdt_pkg::CFG_FIELD_LENGTH: r_field_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a character beat moves whenever the first pipeline stage can take a
    // result, so the parser never waits on a stalled result beyond that
    assign accept = s_axis_tvalid && s_axis_tready;

    sdt_parser #(
        .MAX_STRING(MAX_STRING)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_char         (s_axis_tdata),
        .i_last         (s_axis_tlast),
        .i_start_offset (r_start_offset),
        .i_field_length (r_field_length),
        .o_fin_valid    (fin_valid),
        .o_fin          (fin)
    );

    // fields -> total hundredths of a second -> rounded divide by 3600
    sdt_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fin_valid),
        .i_fin   (fin),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_value (value),
        .o_fail  (m_axis_tuser)
    );

    // pad the value up to whole bytes
    assign m_axis_tdata = {6'd0, value};

endmodule

// File: sv/sdt_parser.sv
// ----------------------------------------------------------------------------
// sdt_parser
// Character-at-a-time field parser; hands the closed-out fields on the last beat.
// ----------------------------------------------------------------------------
module sdt_parser #(
    parameter int MAX_STRING = sdt_pkg::MAX_STRING_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_char,
    input  logic                       i_last,
    input  logic [sdt_pkg::CFG_W-1:0]  i_start_offset,
    input  logic [sdt_pkg::CFG_W-1:0]  i_field_length,
    output logic                       o_fin_valid,
    output sdt_pkg::t_parse            o_fin
);
    localparam int PW = $clog2(MAX_STRING + 1);
    localparam int CW = (PW > sdt_pkg::CFG_W + 1) ? PW : sdt_pkg::CFG_W + 1;

    sdt_pkg::t_parse r_st;
    sdt_pkg::t_parse n_st;
    sdt_pkg::t_parse step_st;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   n_pos;
    logic [CW-1:0]   pos_w;
    logic [CW-1:0]   start_w;
    logic            past_start;
    logic            ends;

    assign pos_w      = CW'(r_pos);
    assign start_w    = CW'(i_start_offset);
    assign past_start = pos_w >= start_w;

    always_comb begin
        ends = (i_char == sdt_pkg::CH_NUL) || (pos_w >= CW'(MAX_STRING - 1));
        if (i_field_length != '0 && past_start &&
            (pos_w - start_w) >= CW'(i_field_length)) begin
            ends = 1'b1;
        end

        step_st = r_st;
        if (r_st.phase == sdt_pkg::PH_DEG || r_st.phase == sdt_pkg::PH_MIN ||
            r_st.phase == sdt_pkg::PH_SEC) begin
            if (ends) begin
                step_st = sdt_pkg::f_end_string(r_st);
            end else if (past_start) begin
                step_st = sdt_pkg::f_parse_char(r_st, i_char);
            end
        end

        o_fin       = sdt_pkg::f_end_string(step_st);
        o_fin_valid = i_accept && i_last;

        // start over after each result
        if (i_last) begin
            n_st  = sdt_pkg::PARSE_CLEAR;
            n_pos = '0;
        end else begin
            n_st  = step_st;
            n_pos = (pos_w < CW'(MAX_STRING)) ? r_pos + PW'(1) : r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= sdt_pkg::PARSE_CLEAR;
            r_pos <= '0;
        end else if (i_accept) begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

endmodule

// File: sv/sdt_convert.sv
// ----------------------------------------------------------------------------
// sdt_convert
// Five-stage elastic pipeline: fields to signed hundredths of a degree.
// ----------------------------------------------------------------------------
module sdt_convert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  sdt_pkg::t_parse                 i_fin,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sdt_pkg::VALUE_W-1:0]     o_value,
    output logic                            o_fail
);
    // stage valids and per-stage load enables
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic go0, go1, go2, go3, go4;

    sdt_pkg::t_parse r_s0;

    logic [28:0] r_p_deg;
    logic [25:0] r_p_min;
    logic [23:0] r_p_sec;
    logic        r_neg1, r_fail1;

    logic [28:0] sum2;
    logic [24:0] r_x;
    logic        r_neg2, r_fail2;

    logic [50:0] prod3;
    logic [sdt_pkg::VALUE_W-1:0] r_mag;
    logic        r_neg3, r_fail3;

    logic [sdt_pkg::VALUE_W-1:0] r_value;
    logic        r_fail4;

    logic [6:0]  frac1;

    assign go4 = !r_v4 || i_ready;
    assign go3 = !r_v3 || go4;
    assign go2 = !r_v2 || go3;
    assign go1 = !r_v1 || go2;
    assign go0 = !r_v0 || go1;

    assign o_ready = go0;
    assign o_valid = r_v4;
    assign o_value = r_value;
    assign o_fail  = r_fail4;

    assign frac1 = (r_s0.fdig == 2'd1) ? 7'(r_s0.frac * 7'd10) : r_s0.frac;
    assign sum2  = r_p_deg + 29'(r_p_min) + 29'(r_p_sec) + 29'd1800;
    assign prod3 = 51'(r_x) * 51'(sdt_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (go0) r_v0 <= i_valid;
            if (go1) r_v1 <= r_v0;
            if (go2) r_v2 <= r_v1;
            if (go3) r_v3 <= r_v2;
            if (go4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go0) r_s0 <= i_fin;
        if (go1) begin
            r_p_deg <= 29'(r_s0.deg) * 29'd360000;
            r_p_min <= 26'(r_s0.min) * 26'd6000;
            r_p_sec <= 24'(r_s0.sec) * 24'd100 + 24'(frac1);
            r_neg1  <= r_s0.neg;
            r_fail1 <= (r_s0.phase == sdt_pkg::PH_FAIL);
        end
        if (go2) begin
            // divide by 16 here, by 225 in the next stage
            r_x     <= sum2[28:4];
            r_neg2  <= r_neg1;
            r_fail2 <= r_fail1;
        end
        if (go3) begin
            r_mag   <= prod3[sdt_pkg::RECIP_SHIFT +: sdt_pkg::VALUE_W];
            r_neg3  <= r_neg2;
            r_fail3 <= r_fail2;
        end
        if (go4) begin
            if (r_fail3) begin
                r_value <= '0;
            end else if (r_neg3) begin
                r_value <= -r_mag;
            end else begin
                r_value <= r_mag;
            end
            r_fail4 <= r_fail3;
        end
    end

endmodule

// File: sv/sdt_checker.sv
// ----------------------------------------------------------------------------
// sdt_checker
// Port-level checks on the sexagesimal text parser, bound to the top level.
// ----------------------------------------------------------------------------
module sdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a failed conversion carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("failed conversion with nonzero value");

    // a good result stays within plus or minus 1200.00 degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            ($signed(m_axis_tdata[17:0]) <= 18'sd120000) &&
            ($signed(m_axis_tdata[17:0]) >= -18'sd120000))
        else $error("result value out of range");

    // input is only held back while the result side is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with a free result slot");

    // no result without a preceding character beat
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready) || $past(s_axis_tvalid, 5)
            || $past(s_axis_tvalid, 4) || !$past(m_axis_tready, 2)
            || !$past(m_axis_tready, 3) || $past(m_axis_tvalid, 2))
        else $error("result appeared without input");

endmodule

bind sexagesimal_text_to_decimal_top sdt_checker u_sdt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_sexagesimal_text_to_decimal_top.sv
// ----------------------------------------------------------------------------
// tb_sexagesimal_text_to_decimal_top
// Self-checking bench for the degrees-minutes-seconds text parser.
// Streams angle strings one character per beat, mirrors the parse in a
// local predictor and checks every converted angle as it leaves the block.
// Covers hand-picked strings, window register settings, random text under
// several idle patterns, and a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_sexagesimal_text_to_decimal_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_CHARS    = sdt_pkg::MAX_STRING_DEF;
    localparam int TEXT_MAX     = 600;
    // result pipeline is a few registers deep; leave some margin
    localparam int DRAIN_PAD    = 12;
    localparam int HOLD_CYCLES  = 400;
    // longest legal quiet stretch is the result hold-off plus random gaps
    localparam int STALL_LIMIT  = 3000;

    localparam int unsigned DEG_CAP = 999;
    localparam int unsigned MIN_CAP = 9999;
    localparam int unsigned SEC_CAP = 99999;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_WRONG = 1'b1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    typedef struct packed {
        logic [17:0] value;
        logic        status;
    } t_angle;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we      = 1'b0;
    logic [sdt_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [sdt_pkg::CFG_W-1:0]      i_cfg_data = '0;

    sexagesimal_text_to_decimal_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .s_axis_tlast  (s_axis_tlast),   // is_last
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [17:0] value_hundredths
        .m_axis_tuser  (m_axis_tuser),   // [0] status
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the parse and of the two registers
    // ------------------------------------------------------------------------
    sdt_pkg::t_phase dms_phase;
    logic [9:0]  deg_acc;
    logic [13:0] min_acc;
    logic [16:0] sec_acc;
    logic [6:0]  frac_acc;
    logic [1:0]  frac_cnt;
    logic        digits_off;
    logic        point_on;
    logic        south_west;
    logic        field_open;
    int unsigned char_pos;
    logic [8:0]  skip_cfg;
    logic [8:0]  span_cfg;

    t_angle      expected_angles[$];

    // stimulus and bookkeeping
    logic [7:0]  text_buf[TEXT_MAX];
    int unsigned text_len;
    int unsigned chars_sent;
    int unsigned send_gap_pct;
    int unsigned ready_stall_pct;
    int unsigned bad_results = 0;
    int unsigned quiet_cycles = 0;
    logic        holding = 1'b0;
    event        hold_results;

    function automatic void restart_parse();
        char_pos   = 0;
        dms_phase  = sdt_pkg::PH_DEG;
        deg_acc    = '0;
        min_acc    = '0;
        sec_acc    = '0;
        frac_acc   = '0;
        frac_cnt   = '0;
        digits_off = 1'b0;
        point_on   = 1'b0;
        south_west = 1'b0;
        field_open = 1'b0;
    endfunction

    function automatic void enter_phase(input sdt_pkg::t_phase ph);
        dms_phase  = ph;
        digits_off = 1'b0;
        point_on   = 1'b0;
        field_open = 1'b0;
    endfunction

    function automatic int unsigned sat_push(input int unsigned acc, input logic [7:0] c,
                                             input int unsigned cap);
        int unsigned v;
        v = acc * 10 + (c - sdt_pkg::CH_ZERO);
        return (v > cap) ? cap : v;
    endfunction

    // One character inside a numeric field: blanks and a plus before the
    // digits, digits with saturation, a point in the seconds field only.
    function automatic void field_char(input logic [7:0] c);
        if (digits_off)
            return;
        if (c >= sdt_pkg::CH_ZERO && c <= sdt_pkg::CH_NINE) begin
            field_open = 1'b1;
            if (point_on) begin
                if (frac_cnt < 2'd2) begin
                    frac_acc = 7'(frac_acc * 10 + (c - sdt_pkg::CH_ZERO));
                    frac_cnt = frac_cnt + 2'd1;
                end
            end else if (dms_phase == sdt_pkg::PH_DEG) begin
                deg_acc = 10'(sat_push(deg_acc, c, DEG_CAP));
            end else if (dms_phase == sdt_pkg::PH_MIN) begin
                min_acc = 14'(sat_push(min_acc, c, MIN_CAP));
            end else begin
                sec_acc = 17'(sat_push(sec_acc, c, SEC_CAP));
            end
        end else if (c == sdt_pkg::CH_POINT && dms_phase == sdt_pkg::PH_SEC && !point_on) begin
            point_on   = 1'b1;
            field_open = 1'b1;
        end else if (!field_open && c >= sdt_pkg::CH_TAB && c <= sdt_pkg::CH_CR) begin
            // leading blank, skip it
        end else if (!field_open && c == sdt_pkg::CH_PLUS) begin
            field_open = 1'b1;
        end else begin
            digits_off = 1'b1;
        end
    endfunction

    // End of text: an open degree field fails, an open minutes or seconds
    // field is dropped.
    function automatic void close_text();
        if (dms_phase == sdt_pkg::PH_DEG) begin
            dms_phase = sdt_pkg::PH_FAIL;
        end else if (dms_phase == sdt_pkg::PH_MIN) begin
            min_acc   = '0;
            dms_phase = sdt_pkg::PH_DONE;
        end else if (dms_phase == sdt_pkg::PH_SEC) begin
            sec_acc   = '0;
            frac_acc  = '0;
            frac_cnt  = '0;
            dms_phase = sdt_pkg::PH_DONE;
        end
    endfunction

    // Advance the parse by one accepted beat; queue the angle on the last one.
    function automatic void advance_parse(input logic [7:0] c, input logic last);
        logic            cut;
        logic            sep;
        logic            up;
        logic            down;
        longint unsigned total;
        longint unsigned mag;
        t_angle          res;
        if (dms_phase == sdt_pkg::PH_DEG || dms_phase == sdt_pkg::PH_MIN ||
            dms_phase == sdt_pkg::PH_SEC) begin
            cut = (c == sdt_pkg::CH_NUL) || (char_pos >= MAX_CHARS - 1);
            if (span_cfg != 0 && char_pos >= skip_cfg && char_pos - skip_cfg >= span_cfg)
                cut = 1'b1;
            if (cut) begin
                close_text();
            end else if (char_pos >= skip_cfg) begin
                sep  = (c == sdt_pkg::CH_DASH) || (c == sdt_pkg::CH_COLON) ||
                       (c == sdt_pkg::CH_SPACE);
                up   = (c == sdt_pkg::CH_N) || (c == sdt_pkg::CH_E);
                down = (c == sdt_pkg::CH_S) || (c == sdt_pkg::CH_W);
                if (dms_phase == sdt_pkg::PH_DEG) begin
                    if (sep)
                        enter_phase(sdt_pkg::PH_MIN);
                    else
                        field_char(c);
                end else if (sep || up || down) begin
                    if (up)
                        south_west = 1'b0;
                    if (down)
                        south_west = 1'b1;
                    enter_phase((dms_phase == sdt_pkg::PH_MIN) ? sdt_pkg::PH_SEC
                                                               : sdt_pkg::PH_DONE);
                end else begin
                    field_char(c);
                end
            end
        end
        if (char_pos < MAX_CHARS)
            char_pos++;
        if (last) begin
            close_text();
            if (dms_phase == sdt_pkg::PH_FAIL) begin
                res.value  = '0;
                res.status = STATUS_WRONG;
            end else begin
                // everything in hundredths of an arc second, then round to
                // hundredths of a degree, half away from zero
                total = longint'(deg_acc) * 360000 + longint'(min_acc) * 6000 +
                        longint'(sec_acc) * 100 +
                        ((frac_cnt == 2'd1) ? longint'(frac_acc) * 10 : longint'(frac_acc));
                mag        = (total + 1800) / 3600;
                res.value  = south_west ? 18'(0 - mag) : 18'(mag);
                res.status = STATUS_OK;
            end
            expected_angles.push_back(res);
            restart_parse();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check each beat, then pick the next tready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_angle want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, $signed(m_axis_tdata[17:0]), m_axis_tuser);
                bad_results++;
            end else begin
                want = expected_angles.pop_front();
                if (m_axis_tdata[17:0] !== want.value) begin
                    $display("%0t: value_hundredths mismatch, expected %0d actual %0d",
                             $time, $signed(want.value), $signed(m_axis_tdata[17:0]));
                    bad_results++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    bad_results++;
                end
            end
        end
        m_axis_tready <= !holding && ($urandom_range(99) >= ready_stall_pct);
    end

    // Long hold-off of the result side, timed here rather than in the test
    always begin
        @(hold_results);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding = 1'b0;
    end

    // Watchdog: give up when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void set_idling(input t_idle mode);
        send_gap_pct    = (mode == IDLE_SEND) ? 54 : (mode == IDLE_BOTH) ? 16 : 0;
        ready_stall_pct = (mode == IDLE_RECV) ? 54 : (mode == IDLE_BOTH) ? 16 : 0;
    endfunction

    // Send one character beat, with an optional random gap in front of it.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        advance_parse(c, last);
    endtask

    task automatic append(input logic [7:0] c);
        if (text_len < TEXT_MAX) begin
            text_buf[text_len] = c;
            text_len++;
        end
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append(s[i]);
    endtask

    // Stream the buffered text, tlast on its final character, then clear it.
    task automatic send_text();
        for (int i = 0; i < text_len; i++)
            send_char(text_buf[i], i == text_len - 1);
        chars_sent += text_len;
        text_len = 0;
    endtask

    task automatic say(input string s);
        load_text(s);
        send_text();
    endtask

    // Write both window registers; only call with the block idle.
    task automatic set_window(input logic [8:0] skip, input logic [8:0] span);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sdt_pkg::CFG_START_OFFSET;
        i_cfg_data <= skip;
        @(posedge i_clk);
        i_cfg_addr <= sdt_pkg::CFG_FIELD_LENGTH;
        i_cfg_data <= span;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        skip_cfg = skip;
        span_cfg = span;
    endtask

    // Drop the stream and wait for every queued angle, plus pipeline margin.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(2))
            0:       return sdt_pkg::CH_DASH;
            1:       return sdt_pkg::CH_COLON;
            default: return sdt_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_sign();
        case ($urandom_range(3))
            0:       return sdt_pkg::CH_N;
            1:       return sdt_pkg::CH_E;
            2:       return sdt_pkg::CH_S;
            default: return sdt_pkg::CH_W;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        return sdt_pkg::CH_TAB + 8'($urandom_range(4));
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(6))
            0:       return 8'($urandom_range(255));
            1:       return sdt_pkg::CH_ZERO + 8'($urandom_range(9));
            2:       return pick_sep();
            3:       return pick_sign();
            4:       return sdt_pkg::CH_POINT;
            5:       return sdt_pkg::CH_PLUS;
            default: return pick_blank();
        endcase
    endfunction

    task automatic append_digits(input int unsigned lo, input int unsigned hi);
        repeat ($urandom_range(hi, lo))
            append(sdt_pkg::CH_ZERO + 8'($urandom_range(9)));
    endtask

    // Build one random angle string: mostly well-formed degrees, minutes and
    // seconds with random content, the rest plain noise.
    task automatic make_dms_text();
        int unsigned r;
        if (skip_cfg <= 8) begin
            // filler for the skipped part, now and then a NUL in it
            repeat (skip_cfg)
                append(($urandom_range(29) == 0) ? sdt_pkg::CH_NUL
                                                 : 8'($urandom_range(255, 1)));
        end
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(10, 1))
                append(noise_char());
        end else begin
            if ($urandom_range(7) == 0)
                append(pick_blank());
            if ($urandom_range(7) == 0)
                append(sdt_pkg::CH_PLUS);
            append_digits(1, ($urandom_range(9) == 0) ? 6 : 3);
            if ($urandom_range(11) != 0)
                append(pick_sep());
            append_digits(0, ($urandom_range(9) == 0) ? 6 : 2);
            r = $urandom_range(9);
            if (r < 4)
                append(pick_sign());
            else if (r < 9)
                append(pick_sep());
            append_digits(0, ($urandom_range(9) == 0) ? 7 : 2);
            if ($urandom_range(1) == 0) begin
                append(sdt_pkg::CH_POINT);
                append_digits(0, 3);
            end
            r = $urandom_range(7);
            if (r < 4)
                append(pick_sign());
            else if (r < 6)
                append(pick_sep());
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(4, 1))
                    append(noise_char());
            end
        end
        if (text_len == 0)
            append(noise_char());
    endtask

    task automatic random_strings(input int unsigned n_chars);
        int unsigned goal;
        goal = chars_sent + n_chars;
        while (chars_sent < goal) begin
            make_dms_text();
            send_text();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked strings: field extremes, signs, number forms, early ends.
    task automatic test_directed_forms();
        set_idling(IDLE_NONE);
        set_window(9'd0, 9'd0);
        say("12-30-45N");
        say("0:0:0S");                 // zero magnitude stays +0
        say("999:9999:99999.99W");     // largest fields, most negative
        say("12345 678901 9999999E");  // saturation of every field
        say("7");                      // degree field never closed
        say("45 30");                  // minutes run into the end, dropped
        append(sdt_pkg::CH_TAB);
        append(sdt_pkg::CH_CR);
        say("+5-+10-20.5S");           // blanks and plus, one fraction digit
        say("1-2-3.456E");             // third fraction digit dropped
        say("1-30S-15N");              // S stands, text after the seconds ignored
        say("1-30S");                  // open seconds field dropped
        say("1e5-x3-inf0-nan");        // exponent and word forms stop digits
        say("4.5-30-1");               // point only counts in seconds
        say("1-2-3 junk-9W");          // after seconds, ignore the rest
        say("++1-2-3");                // a second plus stops the field
        load_text("12-");
        append(sdt_pkg::CH_NUL);       // NUL ends the text early
        say("30N");
        append(8'hFF);
        load_text("5-30");
        append(8'h80);
        send_text();
        settle();
    endtask

    // Window registers: extremes, truncation, skipped part, length cap.
    task automatic test_text_window();
        set_idling(IDLE_BOTH);
        set_window(9'd511, 9'd0);      // everything lands in the skipped part
        random_strings(30);
        settle();
        set_window(9'd0, 9'd511);
        random_strings(40);
        settle();
        set_window(9'd0, 9'd5);
        say("12-30-45N");              // cut after the minutes
        say("-1-2-3");
        settle();
        set_window(9'd0, 9'd1);
        say("9-1");
        say("-");
        settle();
        set_window(9'd3, 9'd0);
        load_text("a");
        append(sdt_pkg::CH_NUL);       // NUL inside the skipped part
        say("b12-30-00N");
        say("xyz3-4-5W");
        settle();
        set_window(9'd2, 9'd7);
        random_strings(40);
        settle();
        // text that reaches the length cap in the middle of the seconds
        set_window(9'd504, 9'd0);
        repeat (504)
            append(8'($urandom_range(255, 1)));
        say("12-30-45N");
        settle();
    endtask

    // Random text under every idle pattern, each with two window settings.
    task automatic test_random_streams();
        for (int k = 0; k < 4; k++) begin
            set_idling(t_idle'(k));
            set_window(9'($urandom_range(4)),
                       ($urandom_range(1) == 0) ? 9'd0 : 9'($urandom_range(24, 1)));
            random_strings(100);
            settle();
            set_window(9'd0, 9'd0);
            random_strings(100);
            settle();
        end
    endtask

    // Hold the result side off while short strings keep coming, so the
    // result pipeline fills and the character side has to stall.
    task automatic test_result_backpressure();
        set_idling(IDLE_NONE);
        set_window(9'd0, 9'd0);
        -> hold_results;
        repeat (30) begin
            append_digits(1, 2);
            append(pick_sep());
            append_digits(1, 2);
            append(pick_sign());
            send_text();
        end
        settle();
    endtask

    initial begin
        restart_parse();
        skip_cfg   = '0;
        span_cfg   = '0;
        text_len   = 0;
        chars_sent = 0;
        set_idling(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_forms();
        test_text_window();
        test_random_streams();
        test_result_backpressure();

        if (bad_results == 0 && expected_angles.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/sdt_pkg.sv
sv/sdt_parser.sv
sv/sdt_convert.sv
sv/sexagesimal_text_to_decimal_top.sv
sv/sdt_checker.sv
tb/tb_sexagesimal_text_to_decimal_top.sv
